// File: rtl/aob_pkg.sv
// ----------------------------------------------------------------------------
// Alpha-over blend package
// Shared field widths, payload words, sequencer states and tint scaling.
// ----------------------------------------------------------------------------
package aob_pkg;

    localparam int FRAC_BITS = 15;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * FX_W;
    localparam int CNT_W     = $clog2(FX_W + 1);
    localparam logic [FX_W-1:0] FX_ONE = FX_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [15:0] layer_red;
        logic [15:0] layer_green;
        logic [15:0] layer_blue;
        logic [15:0] layer_alpha;
        logic        frame_end;
    } layer_t;

    typedef struct packed {
        logic [7:0] tint_red;
        logic [7:0] tint_green;
        logic [7:0] tint_blue;
        logic [8:0] tint_alpha;
    } tint_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALPHA,
        ST_NEWA,
        ST_DIV,
        ST_MIX_A,
        ST_MIX_B,
        ST_MIX_W,
        ST_EMIT
    } aob_state_t;

    // Clamp a value to the range 0..ONE.
    function automatic logic [FX_W-1:0] sat_one(input logic [FX_W-1:0] v);
        return (v > FX_ONE) ? FX_ONE : v;
    endfunction

    // Color scaled to 0..255: (x * 255) >> FRAC_BITS, as (x << 8) - x.
    function automatic logic [7:0] scale_color(input logic [FX_W-1:0] x);
        logic [FX_W+7:0] prod;
        prod = ({x, 8'd0}) - {8'd0, x};
        return 8'(prod >> FRAC_BITS);
    endfunction

    // Alpha scaled to 0..256: (x * 256) >> FRAC_BITS.
    function automatic logic [8:0] scale_alpha(input logic [FX_W-1:0] x);
        logic [FX_W+8:0] prod;
        prod = {x, 9'd0} >> 1;
        return 9'(prod >> FRAC_BITS);
    endfunction

endpackage

// File: rtl/aob_mac.sv
// ----------------------------------------------------------------------------
// Alpha-over blend multiply-accumulate unit
// Shared fraction multiplier with an accumulator register.
// ----------------------------------------------------------------------------
module aob_mac (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       clr,
    input  logic [aob_pkg::FX_W-1:0]   op_a,
    input  logic [aob_pkg::FX_W-1:0]   op_b,
    output logic [aob_pkg::PROD_W-1:0] acc
);

    logic [aob_pkg::PROD_W-1:0] acc_reg;
    logic [aob_pkg::PROD_W-1:0] acc_next;
    logic [aob_pkg::PROD_W-1:0] prod;

    assign prod = {{aob_pkg::FX_W{1'b0}}, op_a} * {{aob_pkg::FX_W{1'b0}}, op_b};

    always_comb
    begin
        acc_next = acc_reg;
        if (en)
        begin
            acc_next = (clr ? '0 : acc_reg) + prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: rtl/aob_div.sv
// ----------------------------------------------------------------------------
// Alpha-over blend share divider
// Restoring divider, one quotient bit per cycle: (old << FRAC_BITS) / new.
// ----------------------------------------------------------------------------
module aob_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [aob_pkg::FX_W-1:0] dividend,
    input  logic [aob_pkg::FX_W-1:0] divisor,
    output logic                     done,
    output logic [aob_pkg::FX_W-1:0] quotient
);

    // The quotient never exceeds ONE, so the upper dividend bits only
    // preload the remainder with dividend >> 1.
    logic [aob_pkg::FX_W-1:0]  rem_reg,  rem_next;
    logic [aob_pkg::FX_W-1:0]  quo_reg,  quo_next;
    logic [aob_pkg::FX_W-1:0]  dvs_reg,  dvs_next;
    logic [aob_pkg::CNT_W-1:0] cnt_reg,  cnt_next;
    logic                      bit_reg,  bit_next;
    logic                      zero_reg, zero_next;
    logic                      done_reg, done_next;
    logic [aob_pkg::FX_W:0]    trial;

    assign trial = {rem_reg, bit_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        bit_next  = bit_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend >> 1;
            bit_next  = dividend[0];
            quo_next  = '0;
            dvs_next  = divisor;
            zero_next = (divisor == '0);
            cnt_next  = aob_pkg::CNT_W'(aob_pkg::FX_W);
        end
        else if (cnt_reg != '0)
        begin
            bit_next = 1'b0;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = aob_pkg::FX_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[aob_pkg::FX_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[aob_pkg::FX_W-1:0];
                quo_next = {quo_reg[aob_pkg::FX_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == aob_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        bit_reg  <= bit_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : aob_pkg::sat_one(quo_reg);

endmodule

// File: rtl/alpha_over_blend_accumulator.sv
// ----------------------------------------------------------------------------
// Alpha-over blend accumulator
// Composites color layers into one screen tint and emits it on frame end.
// ----------------------------------------------------------------------------
// A layer with nonzero alpha holds the block from acceptance until it takes the
// next word: the 16-step share division keeps the sequencer in its divide state,
// and then the seven products run on the single shared multiplier.
// A layer with zero alpha goes straight to the emit state. A frame end loads its
// tint word in the emit state; a second tint waits until the first is gone.
// Reset clears the accumulator, the sequencer and the tint valid flag.
module alpha_over_blend_accumulator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            layer_valid,
    output logic            layer_stall,
    input  aob_pkg::layer_t layer,
    output logic            tint_valid,
    input  logic            tint_stall,
    output aob_pkg::tint_t  tint
);

    localparam int W = aob_pkg::FX_W;

    aob_pkg::aob_state_t state_reg, state_next;

    // Accumulated red, green, blue and alpha.
    logic [W-1:0] accum_reg [4];
    logic [W-1:0] accum_next [4];

    // Captured layer, already clamped to ONE.
    logic [W-1:0] color_reg [3];
    logic [W-1:0] alpha_reg;
    logic         frame_end_reg;

    logic [1:0]   chan_reg, chan_next;

    logic           tint_valid_reg, tint_valid_next;
    aob_pkg::tint_t tint_reg, tint_next;

    logic                 accept;
    logic                 mac_en;
    logic                 mac_clr;
    logic [W-1:0]         mac_a;
    logic [W-1:0]         mac_b;
    logic [2*W-1:0]       mac_acc;
    logic                 div_start;
    logic                 div_done;
    logic [W-1:0]         share;
    logic [W-1:0]         keep_new;
    logic [W-1:0]         new_alpha;
    logic [W:0]           mix_hi;
    logic [W-1:0]         mix_val;
    logic                 emit_ok;

    assign accept   = layer_valid && !layer_stall;
    assign keep_new = aob_pkg::FX_ONE - share;

    // New total alpha: old + ((ONE - old) * a) >> FRAC_BITS, from the MAC.
    assign new_alpha = accum_reg[3] + W'(mac_acc >> aob_pkg::FRAC_BITS);

    // Mixed channel after the two products have been summed.
    assign mix_hi  = mac_acc[aob_pkg::FRAC_BITS +: (W + 1)];
    assign mix_val = (mix_hi > {1'b0, aob_pkg::FX_ONE}) ? aob_pkg::FX_ONE : W'(mix_hi);

    // The tint register may be reloaded once the previous word has left.
    assign emit_ok = !tint_valid_reg || !tint_stall;

    aob_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (mac_en),
        .clr   (mac_clr),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (mac_acc)
    );

    aob_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (accum_reg[3]),
        .divisor  (new_alpha),
        .done     (div_done),
        .quotient (share)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aob_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (aob_pkg::sat_one(layer.layer_alpha) == '0)
                    begin
                        state_next = aob_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = aob_pkg::ST_ALPHA;
                    end
                end
            end
            aob_pkg::ST_ALPHA: state_next = aob_pkg::ST_NEWA;
            aob_pkg::ST_NEWA:  state_next = aob_pkg::ST_DIV;
            aob_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = aob_pkg::ST_MIX_A;
                end
            end
            aob_pkg::ST_MIX_A: state_next = aob_pkg::ST_MIX_B;
            aob_pkg::ST_MIX_B: state_next = aob_pkg::ST_MIX_W;
            aob_pkg::ST_MIX_W:
            begin
                if (chan_reg == 2'd2)
                begin
                    state_next = aob_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = aob_pkg::ST_MIX_A;
                end
            end
            aob_pkg::ST_EMIT:
            begin
                if (!frame_end_reg || emit_ok)
                begin
                    state_next = aob_pkg::ST_IDLE;
                end
            end
            default: state_next = aob_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath updates.
    always_comb
    begin
        layer_stall     = 1'b1;
        mac_en          = 1'b0;
        mac_clr         = 1'b0;
        mac_a           = '0;
        mac_b           = '0;
        div_start       = 1'b0;
        chan_next       = chan_reg;
        tint_next       = tint_reg;
        tint_valid_next = tint_valid_reg && tint_stall;
        for (int i = 0; i < 4; i++)
        begin
            accum_next[i] = accum_reg[i];
        end
        case (state_reg)
            aob_pkg::ST_IDLE:
            begin
                layer_stall = 1'b0;
                chan_next   = 2'd0;
            end
            aob_pkg::ST_ALPHA:
            begin
                mac_en  = 1'b1;
                mac_clr = 1'b1;
                mac_a   = aob_pkg::FX_ONE - accum_reg[3];
                mac_b   = alpha_reg;
            end
            aob_pkg::ST_NEWA:
            begin
                // The divider samples the old alpha before it is replaced.
                div_start     = 1'b1;
                accum_next[3] = aob_pkg::sat_one(new_alpha);
            end
            aob_pkg::ST_MIX_A:
            begin
                mac_en  = 1'b1;
                mac_clr = 1'b1;
                mac_a   = accum_reg[chan_reg];
                mac_b   = share;
            end
            aob_pkg::ST_MIX_B:
            begin
                mac_en = 1'b1;
                mac_a  = color_reg[chan_reg];
                mac_b  = keep_new;
            end
            aob_pkg::ST_MIX_W:
            begin
                accum_next[chan_reg] = mix_val;
                chan_next            = chan_reg + 2'd1;
            end
            aob_pkg::ST_EMIT:
            begin
                if (frame_end_reg && emit_ok)
                begin
                    tint_valid_next       = 1'b1;
                    tint_next.tint_red    = aob_pkg::scale_color(accum_reg[0]);
                    tint_next.tint_green  = aob_pkg::scale_color(accum_reg[1]);
                    tint_next.tint_blue   = aob_pkg::scale_color(accum_reg[2]);
                    tint_next.tint_alpha  = aob_pkg::scale_alpha(accum_reg[3]);
                    for (int i = 0; i < 4; i++)
                    begin
                        accum_next[i] = '0;
                    end
                end
            end
            default:
            begin
                layer_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= aob_pkg::ST_IDLE;
            chan_reg       <= 2'd0;
            tint_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                accum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            chan_reg       <= chan_next;
            tint_valid_reg <= tint_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                accum_reg[i] <= accum_next[i];
            end
        end
    end

    // Layer capture and the tint word need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            color_reg[0]  <= aob_pkg::sat_one(layer.layer_red);
            color_reg[1]  <= aob_pkg::sat_one(layer.layer_green);
            color_reg[2]  <= aob_pkg::sat_one(layer.layer_blue);
            alpha_reg     <= aob_pkg::sat_one(layer.layer_alpha);
            frame_end_reg <= layer.frame_end;
        end
        tint_reg <= tint_next;
    end

    assign tint_valid = tint_valid_reg;
    assign tint       = tint_reg;

endmodule

// File: rtl/aob_checker.sv
// ----------------------------------------------------------------------------
// Alpha-over blend port checker
// Watches the top level's ports over time; attached to it by bind.
// ----------------------------------------------------------------------------
module aob_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            layer_valid,
    input logic            layer_stall,
    input aob_pkg::layer_t layer,
    input logic            tint_valid,
    input logic            tint_stall,
    input aob_pkg::tint_t  tint
);

    // A stalled tint word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        tint_valid && tint_stall |=> tint_valid)
        else $error("tint word dropped while stalled");

    // A stalled tint word does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        tint_valid && tint_stall |=> $stable(tint))
        else $error("tint word changed while stalled");

    // Every accepted layer keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        layer_valid && !layer_stall |=> layer_stall)
        else $error("layer word taken in two consecutive cycles");

    // A stalled layer word does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        layer_valid && layer_stall |=> $stable(layer))
        else $error("layer word changed while stalled");

    // The accumulated alpha never exceeds one, so the tint alpha stays at or below 256.
    assert property (@(posedge clk) disable iff (!rst_n)
        tint_valid |-> tint.tint_alpha <= 9'd256)
        else $error("tint alpha out of range");

endmodule

bind alpha_over_blend_accumulator aob_checker u_aob_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .layer_valid (layer_valid),
    .layer_stall (layer_stall),
    .layer       (layer),
    .tint_valid  (tint_valid),
    .tint_stall  (tint_stall),
    .tint        (tint)
);

// File: dv/alpha_over_blend_checker.sv
// ----------------------------------------------------------------------------
// Alpha-over blend checker
// Watches the layer and tint channels, predicts each tint word from the
// layers accepted so far and compares it field by field with what arrives.
// ----------------------------------------------------------------------------
module alpha_over_blend_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            layer_valid,
    input  logic            layer_stall,
    input  aob_pkg::layer_t layer,
    input  logic            tint_valid,
    input  logic            tint_stall,
    input  aob_pkg::tint_t  tint,
    output int              mismatches,
    output int              pending,
    output int              tints_checked,
    output int              layers_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Wide enough that no product or shifted dividend can overflow.
    typedef logic [47:0] wide_t;

    localparam wide_t UNITY = wide_t'(1) << aob_pkg::FRAC_BITS;

    wide_t           acc_red, acc_green, acc_blue, acc_alpha;
    aob_pkg::tint_t  tint_due_q[$];

    function automatic wide_t clamp_unity(input wide_t v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    // Composites one layer over the running tint with the "over" rule.
    task automatic blend_layer(input aob_pkg::layer_t w);
        wide_t r, g, b, a, old_a, new_a, share, keep;
        r = clamp_unity(wide_t'(w.layer_red));
        g = clamp_unity(wide_t'(w.layer_green));
        b = clamp_unity(wide_t'(w.layer_blue));
        a = clamp_unity(wide_t'(w.layer_alpha));
        if (a != 0)
        begin
            old_a = acc_alpha;
            new_a = old_a + (((UNITY - old_a) * a) >> aob_pkg::FRAC_BITS);
            share = (new_a != 0) ? ((old_a << aob_pkg::FRAC_BITS) / new_a) : '0;
            share = clamp_unity(share);
            keep  = UNITY - share;
            acc_red   = clamp_unity((acc_red   * share + r * keep) >> aob_pkg::FRAC_BITS);
            acc_green = clamp_unity((acc_green * share + g * keep) >> aob_pkg::FRAC_BITS);
            acc_blue  = clamp_unity((acc_blue  * share + b * keep) >> aob_pkg::FRAC_BITS);
            acc_alpha = clamp_unity(new_a);
        end
    endtask

    function automatic aob_pkg::tint_t scaled_tint();
        aob_pkg::tint_t t;
        t.tint_red   = 8'((acc_red   * 255) >> aob_pkg::FRAC_BITS);
        t.tint_green = 8'((acc_green * 255) >> aob_pkg::FRAC_BITS);
        t.tint_blue  = 8'((acc_blue  * 255) >> aob_pkg::FRAC_BITS);
        t.tint_alpha = 9'((acc_alpha * 256) >> aob_pkg::FRAC_BITS);
        return t;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        aob_pkg::tint_t want;
        if (!rst_n)
        begin
            acc_red       = '0;
            acc_green     = '0;
            acc_blue      = '0;
            acc_alpha     = '0;
            tint_due_q.delete();
            mismatches    = 0;
            pending       = 0;
            tints_checked = 0;
            layers_seen   = 0;
        end
        else
        begin
            // The tint word taken at this edge comes from an earlier layer, so
            // it is matched before the layer taken at the same edge is applied.
            if (tint_valid && !tint_stall)
            begin
                if (tint_due_q.size() == 0)
                begin
                    $error("tint word arrived with no frame end waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = tint_due_q.pop_front();
                    check_field("tint_red",   want.tint_red,   tint.tint_red);
                    check_field("tint_green", want.tint_green, tint.tint_green);
                    check_field("tint_blue",  want.tint_blue,  tint.tint_blue);
                    check_field("tint_alpha", want.tint_alpha, tint.tint_alpha);
                    tints_checked++;
                end
            end
            if (layer_valid && !layer_stall)
            begin
                blend_layer(layer);
                layers_seen++;
                if (layer.frame_end)
                begin
                    tint_due_q.push_back(scaled_tint());
                    acc_red   = '0;
                    acc_green = '0;
                    acc_blue  = '0;
                    acc_alpha = '0;
                end
            end
            pending = tint_due_q.size();
        end
    end

endmodule

// File: dv/alpha_over_blend_accumulator_test.sv
// ----------------------------------------------------------------------------
// Alpha-over blend accumulator test
// Drives directed and random layer words into the blend accumulator with
// random idle and stall bursts on both channels; a checker beside the block
// predicts every tint word and reports mismatches back here for the verdict.
// ----------------------------------------------------------------------------
module alpha_over_blend_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Number of layer words that actually reach the blend logic (nonzero
    // alpha or frame end) before the random part stops.
    localparam int LAYER_TARGET   = 750;
    // The last stretch of the run runs with no idling on either side.
    localparam int TAIL_LAYERS    = 60;
    // The time a layer holds the block, plus the longest sender gap and
    // receiver stall, taken many times over.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to wait after the last tint word so that a stray word shows up.
    localparam int SETTLE_CYCLES  = 40;
    // How many counted layers pass between forced drains of the tint queue.
    localparam int DRAIN_EVERY    = 250;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            layer_valid = 1'b0;
    logic            layer_stall;
    aob_pkg::layer_t layer       = '0;
    logic            tint_valid;
    logic            tint_stall  = 1'b0;
    aob_pkg::tint_t  tint;

    int mismatches, pending, tints_checked, layers_seen;

    int layers_sent  = 0;
    int gap_pct      = 0;
    int quiet_cycles = 0;
    bit quiet_tail   = 1'b0;

    always #4 clk = ~clk;

    alpha_over_blend_accumulator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .layer_valid (layer_valid),
        .layer_stall (layer_stall),
        .layer       (layer),
        .tint_valid  (tint_valid),
        .tint_stall  (tint_stall),
        .tint        (tint)
    );

    alpha_over_blend_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .layer_valid   (layer_valid),
        .layer_stall   (layer_stall),
        .layer         (layer),
        .tint_valid    (tint_valid),
        .tint_stall    (tint_stall),
        .tint          (tint),
        .mismatches    (mismatches),
        .pending       (pending),
        .tints_checked (tints_checked),
        .layers_seen   (layers_seen)
    );

    // The watchdog restarts whenever either channel moves a word. If the
    // block hangs, or a tint word never comes, the count runs out.
    always @(posedge clk)
    begin
        if (!rst_n || (layer_valid && !layer_stall) || (tint_valid && !tint_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d cycles with no word moving",
                         WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver side: random stall bursts, at a rate that is picked anew during
    // the run, so calm stretches alternate with heavy ones. A stall is only
    // ever raised or lowered once per falling edge.
    initial
    begin
        int rx_pct;
        int tick;
        rx_pct = 0;
        tick   = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       rx_pct = 0;
                    1:       rx_pct = 15;
                    default: rx_pct = 50;
                endcase
            end
            if (!quiet_tail && rst_n && $urandom_range(0, 99) < rx_pct)
            begin
                tint_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                tint_stall <= 1'b0;
            end
        end
    end

    // A fraction for one field. Most values lie in 0..1.0, with weight on the
    // edges of that range; a few lie above 1.0 so that saturation is hit.
    function automatic logic [15:0] rand_frac();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return aob_pkg::FX_ONE;
            2:       return 16'($urandom_range(32769, 65535));
            3:       return 16'($urandom_range(1, 15));
            4:       return 16'($urandom_range(32752, 32767));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Presents one layer word at the current falling edge and holds it until
    // the block takes it. Valid stays high into the next word unless an idle
    // burst is drawn, so valid is never dropped and raised at the same edge.
    task automatic send_layer(input logic [15:0] red, input logic [15:0] green,
                              input logic [15:0] blue, input logic [15:0] alpha,
                              input logic fe);
        aob_pkg::layer_t w;
        w.layer_red   = red;
        w.layer_green = green;
        w.layer_blue  = blue;
        w.layer_alpha = alpha;
        w.frame_end   = fe;
        layer_valid <= 1'b1;
        layer       <= w;
        @(posedge clk);
        while (layer_stall)
            @(posedge clk);
        @(negedge clk);
        // Words with zero alpha and no frame end do nothing, so they are not
        // counted toward the target.
        if (alpha != 0 || fe)
            layers_sent++;
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct)
        begin
            layer_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    // Holds the sender back until every predicted tint word has come out.
    task automatic wait_for_tints();
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int n;
        int next_drain;
        bit noisy;
        next_drain = DRAIN_EVERY;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with light idling on the sender.
        gap_pct = 30;
        // An empty frame: nothing accumulated, tint is all zero.
        send_layer(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        // One opaque white layer gives the largest outputs.
        send_layer(aob_pkg::FX_ONE, aob_pkg::FX_ONE, aob_pkg::FX_ONE, aob_pkg::FX_ONE, 1'b1);
        // Every bit set: all fields are above one and must saturate.
        send_layer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // Just above one on some fields, zero on another.
        send_layer(16'd32769, 16'd0, 16'd32769, 16'd32769, 1'b1);
        // Just below one everywhere.
        send_layer(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        // The faintest nonzero alpha.
        send_layer(aob_pkg::FX_ONE, 16'd0, 16'd0, 16'd1, 1'b1);
        // Zero alpha on a frame end: the layer is skipped, the tint still goes.
        send_layer(aob_pkg::FX_ONE, aob_pkg::FX_ONE, aob_pkg::FX_ONE, 16'd0, 1'b1);
        // A layered frame with a zero-alpha word in the middle.
        send_layer(aob_pkg::FX_ONE, 16'd0, 16'd0, 16'd16384, 1'b0);
        send_layer(16'd0, 16'd0, aob_pkg::FX_ONE, 16'd16384, 1'b0);
        send_layer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
        send_layer(16'd0, aob_pkg::FX_ONE, 16'd0, 16'd8192, 1'b1);
        // Opaque layers stacked: alpha stays pinned at one and after the first
        // layer the old color keeps the whole share each time.
        send_layer(16'd12345, 16'd23456, 16'd345, aob_pkg::FX_ONE, 1'b0);
        send_layer(16'd100, 16'd200, 16'd300, aob_pkg::FX_ONE, 1'b0);
        send_layer(16'd32767, 16'd0, 16'd1, 16'd40000, 1'b1);
        // A frame of faint layers, alternating bit patterns in the colors.
        for (int i = 0; i < 6; i++)
            send_layer(16'h5555, 16'h2AAA, 16'h8000, 16'd3000, i == 5);
        // Layer on one word, frame end on a following zero-alpha word.
        send_layer(aob_pkg::FX_ONE, 16'd0, 16'd0, 16'd20000, 1'b0);
        send_layer(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);

        // Random part: mostly well-formed frames of one to six layers, fields
        // mostly in range, ending in a frame end, and now and then a run of raw
        // words with every field and the frame end bit fully random.
        while (layers_sent < LAYER_TARGET)
        begin
            if (LAYER_TARGET - layers_sent <= TAIL_LAYERS)
                quiet_tail = 1'b1;
            if (layers_sent >= next_drain)
            begin
                layer_valid <= 1'b0;
                @(negedge clk);
                wait_for_tints();
                next_drain += DRAIN_EVERY;
            end
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 20;
                default: gap_pct = 60;
            endcase
            n     = $urandom_range(1, 6);
            noisy = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < n; k++)
            begin
                if (noisy)
                    send_layer(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               1'($urandom_range(0, 1)));
                else
                    send_layer(rand_frac(), rand_frac(), rand_frac(), rand_frac(),
                               k == n - 1);
            end
        end

        layer_valid <= 1'b0;
        wait_for_tints();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Run covered %0d layer words and %0d tint words checked,",
                 layers_seen, tints_checked);
        $display("including saturated fields, zero-alpha layers and stacked frames.");
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
rtl/aob_pkg.sv
rtl/aob_mac.sv
rtl/aob_div.sv
rtl/alpha_over_blend_accumulator.sv
rtl/aob_checker.sv
dv/alpha_over_blend_checker.sv
dv/alpha_over_blend_accumulator_test.sv
